// ===== hw/rtl/tsol_pkg.sv =====
// Package for the transpose self-organizing list: field widths, command and
// status codes, default parameter values and the result record.
// No dependencies.
package tsol_pkg;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int HIT_W    = 32;
    localparam int OCC_W    = 5;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 32;

    // command codes; the fourth code is unused and answers as a miss
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [HIT_W-1:0]    hit_count;
        logic [OCC_W-1:0]    occupancy;
    } t_result;

endpackage

// ===== hw/rtl/tsol_channels.sv =====
// Valid/ready channel interfaces of the transpose self-organizing list:
// the command channel and the response channel.
// Depends on tsol_pkg.
interface tsol_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [tsol_pkg::CMD_W-1:0] cmd;
    logic [tsol_pkg::KEY_W-1:0] key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface tsol_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tsol_pkg::STATUS_W-1:0] status;
    logic [tsol_pkg::POS_W-1:0]    position;
    logic [tsol_pkg::HIT_W-1:0]    hit_count;
    logic [tsol_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output position, output hit_count,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input position, input hit_count,
                    input occupancy, output ready);
endinterface

// ===== hw/rtl/transpose_self_organizing_list.sv =====
// Transpose self-organizing list: top level with sequencer and table memory.
// Depends on tsol_pkg, tsol_channels and tsol_rsp_buf.
//
// Usage:
//   i_cmd carries one command per transaction (insert, search, remove) with a
//   key; o_rsp returns exactly one response transaction per command with
//   status, position, hit count and occupancy.
//   Commands are taken one at a time: i_cmd.ready is high only while idle, so
//   a new command is accepted only once the last one has handed over its response.
// Sequence per command: an insert, an unused code or any lookup on an empty
//   table goes straight to the done state; a search or remove scans the
//   entries from position 0 up to a hit or the last occupied entry; a search
//   hit writes back the incremented hit count and, above position 0, swaps
//   with its predecessor; a remove hit then shifts the later entries down.
// The scan reads one table entry per cycle, and the remove shift moves one
// entry per cycle.
// Reset clears the occupancy and the sequencer; table contents are not
// cleared, since only entries below the occupancy are ever used.
// Stall: a finished response waits in the output register; the next command
// is accepted meanwhile and finishes up to the point of handing over its
// response, where it waits until the register frees.
module transpose_self_organizing_list #(
    parameter int CAPACITY  = tsol_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = tsol_pkg::KEY_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsol_cmd_if.sink   i_cmd,
    tsol_rsp_if.source o_rsp
);
    import tsol_pkg::*;

    // stored key width: only the low KEY_WIDTH bits of the key take part
    localparam int KW = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = KW + HIT_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SWAP  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_total, n_total;
    logic [KW-1:0]    r_key, n_key;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    t_result          r_res, n_res;
    logic [MW-1:0]    r_prev;

    // table memory: {key, hit count} per entry, one write and one read port
    logic [MW-1:0]    r_mem [CAPACITY];
    logic [MW-1:0]    r_rd;
    logic             mem_we;
    logic [IW-1:0]    mem_wa;
    logic [MW-1:0]    mem_wd;
    logic [IW-1:0]    mem_ra;

    logic             acc;
    logic [KW-1:0]    in_key;
    logic [KW-1:0]    rd_key;
    logic [HIT_W-1:0] rd_cnt;
    logic [HIT_W-1:0] cnt_inc;
    logic             hit;
    logic             last;
    logic [31:0]      idx_ext;
    logic [31:0]      total_ext;
    logic             push;
    logic             room;
    t_result          rsp_in;

    assign acc       = i_cmd.valid && i_cmd.ready;
    assign in_key    = i_cmd.key[KW-1:0];
    assign rd_key    = r_rd[MW-1 -: KW];
    assign rd_cnt    = r_rd[HIT_W-1:0];
    assign cnt_inc   = (rd_cnt == '1) ? rd_cnt : rd_cnt + HIT_W'(1);
    assign hit       = (rd_key == r_key);
    // current index is the last occupied entry
    assign last      = ((CW'(r_idx) + CW'(1)) == r_total);
    assign idx_ext   = 32'(r_idx);
    assign total_ext = 32'(r_total);

    assign i_cmd.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_total = r_total;
        n_key   = r_key;
        n_cmd   = r_cmd;
        n_res   = r_res;
        mem_we  = 1'b0;
        mem_wa  = r_idx;
        mem_wd  = r_rd;
        mem_ra  = '0;
        push    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_key = in_key;
                    n_cmd = i_cmd.cmd;
                    n_res = '{status: ST_MISS, position: '0, hit_count: '0, occupancy: '0};
                    priority if (i_cmd.cmd == CMD_INSERT) begin
                        if (r_total == CW'(CAPACITY)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            mem_we         = 1'b1;
                            mem_wa         = r_total[IW-1:0];
                            mem_wd         = {in_key, {HIT_W{1'b0}}};
                            n_res.status   = ST_OK;
                            n_res.position = total_ext[POS_W-1:0];
                            n_total        = r_total + CW'(1);
                        end
                        n_state = S_DONE;
                    end else if ((i_cmd.cmd == CMD_SEARCH || i_cmd.cmd == CMD_REMOVE)
                                 && r_total != '0) begin
                        n_idx   = '0;
                        mem_ra  = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                // r_rd holds entry r_idx; fetch the next one meanwhile
                mem_ra = r_idx + IW'(1);
                if (hit) begin
                    n_res.status   = ST_OK;
                    n_res.position = idx_ext[POS_W-1:0];
                    if (r_cmd == CMD_SEARCH) begin
                        n_res.hit_count = cnt_inc;
                        mem_we          = 1'b1;
                        mem_wd          = {r_key, cnt_inc};
                        if (r_idx == '0) begin
                            mem_wa  = '0;
                            n_state = S_DONE;
                        end else begin
                            // found entry moves up; predecessor written next
                            mem_wa  = r_idx - IW'(1);
                            n_state = S_SWAP;
                        end
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (last) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_SWAP: begin
                mem_we  = 1'b1;
                mem_wa  = r_idx;
                mem_wd  = r_prev;
                n_state = S_DONE;
            end
            S_SHIFT: begin
                // r_rd holds entry r_idx + 1, copied down into r_idx
                mem_ra = r_idx + IW'(2);
                if (last) begin
                    n_total = r_total - CW'(1);
                    n_state = S_DONE;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = r_idx;
                    mem_wd = r_rd;
                    n_idx  = r_idx + IW'(1);
                end
            end
            S_DONE: begin
                if (room) begin
                    push    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        rsp_in           = r_res;
        rsp_in.occupancy = total_ext[OCC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_key <= n_key;
        r_cmd <= n_cmd;
        r_res <= n_res;
        // keep the last entry that missed: the predecessor of a later hit
        if (r_state == S_SCAN && !hit) begin
            r_prev <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    tsol_rsp_buf u_rsp_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (rsp_in),
        .o_room  (room),
        .o_rsp   (o_rsp)
    );

`ifndef SYNTH
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_cmd.cmd == CMD_INSERT && r_total != CW'(CAPACITY))
        |=> (r_total == $past(r_total) + CW'(1)))
        else $error("insert did not grow occupancy");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SHIFT) |-> (CW'(r_idx) < r_total))
        else $error("scan index beyond occupied entries");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && last) |=> (r_total == $past(r_total) - CW'(1)))
        else $error("remove did not shrink occupancy");
`endif

endmodule

// ===== hw/rtl/tsol_rsp_buf.sv =====
// Response output register: holds one finished result until the receiver
// takes it. Depends on tsol_pkg and tsol_channels.
module tsol_rsp_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tsol_pkg::t_result i_res,
    output logic              o_room,
    tsol_rsp_if.source        o_rsp
);
    import tsol_pkg::*;

    logic    r_valid;
    t_result r_data;

    // slot is free if empty or being drained this cycle
    assign o_room = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_res;
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.status    = r_data.status;
    assign o_rsp.position  = r_data.position;
    assign o_rsp.hit_count = r_data.hit_count;
    assign o_rsp.occupancy = r_data.occupancy;

endmodule
